// ===== hdl/dmc_pkg.sv =====
// Shared types, constants and the rate table of the delta modulation sample channel.
package dmc_pkg;

	localparam logic [15:0] ADDR_WRAP = 16'h8000;
	localparam logic [1:0]  ADDR_BASE_TOP = 2'b11;	// 0xC000 base: top two address bits
	localparam logic [6:0]  LEVEL_TOP = 7'd125;
	localparam logic [3:0]  BITS_FULL = 4'd8;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_CONTROL   = 3'd1,
		CMD_LEVEL     = 3'd2,
		CMD_ADDRESS   = 3'd3,
		CMD_LENGTH    = 3'd4,
		CMD_START     = 3'd5,
		CMD_STOP      = 3'd6
	} cmd_e;

	typedef struct packed {
		logic [7:0]  shift_bits;
		logic [3:0]  bits_left;
		logic [6:0]  level;
		logic [15:0] cur_addr;
		logic [11:0] remaining;
		logic [15:0] start_addr;
		logic [11:0] start_len;
		logic        loop_en;
		logic [3:0]  rate_idx;
		logic [7:0]  timer;
	} chan_state_t;

	function automatic logic [7:0] rate_period(input logic [3:0] idx);
		logic [7:0] p;
		case (idx)
			4'd0:    p = 8'd214;
			4'd1:    p = 8'd190;
			4'd2:    p = 8'd170;
			4'd3:    p = 8'd160;
			4'd4:    p = 8'd143;
			4'd5:    p = 8'd127;
			4'd6:    p = 8'd113;
			4'd7:    p = 8'd107;
			4'd8:    p = 8'd95;
			4'd9:    p = 8'd80;
			4'd10:   p = 8'd71;
			4'd11:   p = 8'd64;
			4'd12:   p = 8'd53;
			4'd13:   p = 8'd42;
			4'd14:   p = 8'd36;
			default: p = 8'd27;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/delta_modulation_sample_channel.sv =====
// Top level of the delta modulation sample channel: input stage, state and result register.
//
//  channel | dir | data bits                                   | handshake
//  s_axis  | in  | tdata[18:0]: command, write_data, mem_byte  | tvalid/tready
//  m_axis  | out | tdata[35:0]: level, fetch_address,          | tvalid/tready
//          |     |   bytes_remaining, byte_taken               |
//
// One word per cycle sustained while m_axis is not stalled; an accepted word passes
// the input register, then the result register (with the state update) that drives m_axis.
// arst_n clears the channel state and both valid flags.
// A stalled m_axis holds the result; the input register takes one more word,
// then s_axis_tready drops until the result is taken.
module delta_modulation_sample_channel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,	// [2:0] command, [10:3] write_data, [18:11] mem_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata	// [6:0] level, [22:7] fetch_address,
						// [34:23] bytes_remaining, [35] byte_taken
);
	import dmc_pkg::*;

	logic        vld_s1;
	logic [2:0]  cmd_s1;
	logic [7:0]  data_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	chan_state_t state_q;
	chan_state_t state_nxt;
	logic        taken;

	assign advance       = vld_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tdata[2:0];
			data_s1 <= s_axis_tdata[10:3];
			byte_s1 <= s_axis_tdata[18:11];
		end
	end

	dmc_step u_step (
		.cur        (state_q),
		.command    (cmd_s1),
		.write_data (data_s1),
		.mem_byte   (byte_s1),
		.nxt        (state_nxt),
		.byte_taken (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= {4'd0, taken, state_nxt.remaining, state_nxt.cur_addr,
				state_nxt.level};
		end
	end

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bits_left <= BITS_FULL)
		else $error("shifter bit count above eight");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining <= 12'd4081 && state_q.start_len <= 12'd4081)
		else $error("byte count out of range");

	a_taken_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 != CMD_TICK |=> !m_axis_tdata[35])
		else $error("byte taken on a non-tick command");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked result");

	a_taken_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance && taken |=> state_q.bits_left >= 4'd7)
		else $error("fetched byte did not fill the shifter");

endmodule

// ===== hdl/dmc_step.sv =====
// Next-state logic of the channel for one command word.
module dmc_step (
	input  dmc_pkg::chan_state_t cur,
	input  logic [2:0]           command,
	input  logic [7:0]           write_data,
	input  logic [7:0]           mem_byte,
	output dmc_pkg::chan_state_t nxt,
	output logic                 byte_taken
);
	import dmc_pkg::*;

	dmc_pkg::chan_state_t f;	// state after the fetch part of a tick
	logic [15:0] addr_inc;
	logic [11:0] rem_dec;
	logic        fire;
	logic        fetch_ok;

	assign addr_inc = cur.cur_addr + 16'd1;
	assign rem_dec  = cur.remaining - 12'd1;

	always_comb begin
		f = cur;
		fetch_ok = 1'b0;
		if (cur.remaining != 12'd0 && cur.bits_left == 4'd0) begin
			fetch_ok     = 1'b1;
			f.shift_bits = mem_byte;
			f.bits_left  = BITS_FULL;
			f.cur_addr   = (addr_inc == 16'd0) ? ADDR_WRAP : addr_inc;
			f.remaining  = rem_dec;
			if (rem_dec == 12'd0 && cur.loop_en) begin
				f.cur_addr  = cur.start_addr;
				f.remaining = cur.start_len;
			end
		end
	end

	// only a tick consumes the memory byte
	assign byte_taken = fetch_ok && (command == CMD_TICK);

	assign fire = (cur.timer == 8'd0);

	always_comb begin
		nxt = cur;
		case (command)
			CMD_TICK: begin
				nxt = f;
				nxt.timer = fire ? rate_period(cur.rate_idx) : cur.timer - 8'd1;
				if (fire && f.bits_left != 4'd0) begin
					if (f.shift_bits[0]) begin
						if (f.level <= LEVEL_TOP)
							nxt.level = f.level + 7'd2;
					end else begin
						if (f.level >= 7'd2)
							nxt.level = f.level - 7'd2;
					end
					nxt.shift_bits = {1'b0, f.shift_bits[7:1]};
					nxt.bits_left  = f.bits_left - 4'd1;
				end
			end
			CMD_CONTROL: begin
				nxt.rate_idx = write_data[3:0];
				nxt.loop_en  = write_data[6];
			end
			CMD_LEVEL:   nxt.level = write_data[6:0];
			CMD_ADDRESS: nxt.start_addr = {ADDR_BASE_TOP, write_data, 6'd0};
			CMD_LENGTH:  nxt.start_len = {write_data, 4'd1};
			CMD_START: begin
				nxt.cur_addr  = cur.start_addr;
				nxt.remaining = cur.start_len;
			end
			CMD_STOP:    nxt.remaining = 12'd0;
			default:     nxt = cur;
		endcase
	end

endmodule
